// ----- src/hwd_pkg.sv -----
// hwd_pkg: shared types and constants of the tree-walk decoder.
// Used by every module under src; depends on nothing.
package hwd_pkg;

   localparam int NUM_SYMBOLS = 256;
   localparam int SYM_W = 8;
   localparam int PTR_W = 9;
   localparam int CHILD_W = 2 * PTR_W;
   localparam int NUM_NODES = NUM_SYMBOLS - 1;
   localparam logic [PTR_W-1:0] HEADER_BYTES = PTR_W'(2 * NUM_NODES);
   localparam logic [PTR_W-1:0] HEADER_LAST = PTR_W'(2 * NUM_NODES - 1);
   localparam logic [SYM_W-1:0] NODE_NONE = 8'hFF;

   typedef struct packed {
      logic [SYM_W-1:0] data_byte;
      logic             start_of_file;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] decoded_symbol;
      logic             last_of_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_PAIR_FIRST,
      KIND_PAIR_SECOND,
      KIND_PAYLOAD
   } kind_type;

   // classified word handed from the front end to the back end
   typedef struct packed {
      kind_type         kind;
      logic             clear_slots;
      logic             pair_last;
      logic [SYM_W-1:0] node_idx;
      logic [SYM_W-1:0] data_byte;
   } cmd_type;

   // up to two result words written into the result queue per cycle
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAIR_BUILD,
      ST_WALK
   } state_type;

   // 256..510 are internal nodes; 0..255 and 511 are leaves
   function automatic logic is_internal(input logic [PTR_W-1:0] ptr);
      return ptr[PTR_W-1] && (ptr[SYM_W-1:0] != NODE_NONE);
   endfunction

endpackage

// ----- src/hwd_front.sv -----
// hwd_front: header byte counter, word classifier and two-entry command queue.
// Depends on hwd_pkg.
module hwd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  hwd_pkg::req_type  req_data,
   output logic              cmd_valid,
   output hwd_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   logic [hwd_pkg::PTR_W-1:0] hdr_count_ff, hdr_count_in;
   logic [hwd_pkg::PTR_W-1:0] cur_count;
   hwd_pkg::cmd_type          q_ff [2];
   hwd_pkg::cmd_type          new_cmd;
   logic                      wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                count_ff, count_in;
   logic                      push, pop;

   assign req_full  = (count_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && (count_ff != 2'd0);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // start of file restarts the header count before this word is classified
   assign cur_count = req_data.start_of_file ? '0 : hdr_count_ff;

   always_comb begin
      new_cmd.clear_slots = req_data.start_of_file;
      new_cmd.data_byte   = req_data.data_byte;
      new_cmd.node_idx    = cur_count[hwd_pkg::PTR_W-1:1];
      new_cmd.pair_last   = (cur_count == hwd_pkg::HEADER_LAST);
      hdr_count_in        = hdr_count_ff;
      if (cur_count < hwd_pkg::HEADER_BYTES) begin
         new_cmd.kind = cur_count[0] ? hwd_pkg::KIND_PAIR_SECOND : hwd_pkg::KIND_PAIR_FIRST;
         if (push) begin
            hdr_count_in = cur_count + 9'd1;
         end
      end else begin
         new_cmd.kind = hwd_pkg::KIND_PAYLOAD;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff <= '0;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         hdr_count_ff <= hdr_count_in;
         count_ff     <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- src/hwd_back.sv -----
// hwd_back: tree builder and bit-serial tree walker, with slot and child RAMs.
// Depends on hwd_pkg.
module hwd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  hwd_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   input  logic                  rsp_room,
   output hwd_pkg::rsp_push_type rsp_push
);

   hwd_pkg::state_type state_ff, state_in;

   // slot store: node index per symbol, valid bit set means "points to a node"
   logic [hwd_pkg::SYM_W-1:0]       slot_mem [hwd_pkg::NUM_SYMBOLS];
   logic [hwd_pkg::NUM_SYMBOLS-1:0] slot_valid_ff, slot_valid_in;
   logic [hwd_pkg::SYM_W-1:0]       slot_rd_a_ff, slot_rd_b_ff;
   logic                            slot_rd_en, slot_wr_en;

   // child store: {left, right} per internal node
   logic [hwd_pkg::CHILD_W-1:0] child_mem [hwd_pkg::NUM_NODES];
   logic [hwd_pkg::CHILD_W-1:0] child_rd_ff;
   logic                        child_rd_en, child_wr_en;
   logic [hwd_pkg::SYM_W-1:0]   child_rd_addr;
   logic [hwd_pkg::CHILD_W-1:0] child_wr_data;

   hwd_pkg::cmd_type          cur_ff, cur_in;
   logic [hwd_pkg::SYM_W-1:0] held_ff, held_in;
   logic [hwd_pkg::PTR_W-1:0] root_ff, root_in;
   logic [hwd_pkg::PTR_W-1:0] walk_ff, walk_in;
   logic [2:0]                idx_ff, idx_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [hwd_pkg::SYM_W-1:0] pend_sym_ff, pend_sym_in;

   logic [hwd_pkg::PTR_W-1:0] left_ptr, right_ptr, nxt_ptr, node_ptr;
   logic                      bit_val, emit;

   assign node_ptr  = {1'b1, cur_ff.node_idx};
   assign left_ptr  = slot_valid_ff[held_ff] ? {1'b1, slot_rd_a_ff} : {1'b0, held_ff};
   assign right_ptr = slot_valid_ff[cur_ff.data_byte] ? {1'b1, slot_rd_b_ff}
                                                       : {1'b0, cur_ff.data_byte};
   assign bit_val   = cur_ff.data_byte[idx_ff];
   assign nxt_ptr   = !hwd_pkg::is_internal(walk_ff) ? walk_ff :
                      bit_val ? child_rd_ff[hwd_pkg::PTR_W-1:0]
                              : child_rd_ff[hwd_pkg::CHILD_W-1:hwd_pkg::PTR_W];
   assign emit      = !hwd_pkg::is_internal(nxt_ptr);
   assign child_wr_data = {left_ptr, right_ptr};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      held_in       = held_ff;
      root_in       = root_ff;
      walk_in       = walk_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      slot_valid_in = slot_valid_ff;
      slot_rd_en    = 1'b0;
      slot_wr_en    = 1'b0;
      child_wr_en   = 1'b0;
      child_rd_en   = 1'b0;
      child_rd_addr = walk_ff[hwd_pkg::SYM_W-1:0];
      cmd_pop       = 1'b0;
      rsp_push      = '0;

      unique case (state_ff)
         hwd_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               unique case (cmd.kind)
                  hwd_pkg::KIND_PAIR_FIRST: begin
                     held_in = cmd.data_byte;
                     if (cmd.clear_slots) begin
                        slot_valid_in = '0;
                     end
                  end
                  hwd_pkg::KIND_PAIR_SECOND: begin
                     slot_rd_en = 1'b1;
                     state_in   = hwd_pkg::ST_PAIR_BUILD;
                  end
                  hwd_pkg::KIND_PAYLOAD: begin
                     child_rd_en = hwd_pkg::is_internal(walk_ff);
                     idx_in      = 3'd7;
                     state_in    = hwd_pkg::ST_WALK;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         hwd_pkg::ST_PAIR_BUILD: begin
            child_wr_en            = 1'b1;
            slot_wr_en             = 1'b1;
            slot_valid_in[held_ff] = 1'b1;
            // second symbol returns to its leaf, also when both symbols match
            slot_valid_in[cur_ff.data_byte] = 1'b0;
            if (cur_ff.pair_last) begin
               root_in = (held_ff == cur_ff.data_byte) ? {1'b0, held_ff} : node_ptr;
               walk_in = root_in;
            end
            state_in = hwd_pkg::ST_IDLE;
         end

         hwd_pkg::ST_WALK: begin
            if (rsp_room) begin
               walk_in       = emit ? root_ff : nxt_ptr;
               child_rd_en   = hwd_pkg::is_internal(walk_in);
               child_rd_addr = walk_in[hwd_pkg::SYM_W-1:0];
               idx_in        = idx_ff - 3'd1;
               if (idx_ff == 3'd0) begin
                  // close the byte: the newest symbol carries last_of_byte
                  pend_valid_in = 1'b0;
                  if (emit) begin
                     if (pend_valid_ff) begin
                        rsp_push.num    = 2'd2;
                        rsp_push.first  = '{decoded_symbol: pend_sym_ff, last_of_byte: 1'b0};
                        rsp_push.second = '{decoded_symbol: nxt_ptr[hwd_pkg::SYM_W-1:0],
                                            last_of_byte: 1'b1};
                     end else begin
                        rsp_push.num   = 2'd1;
                        rsp_push.first = '{decoded_symbol: nxt_ptr[hwd_pkg::SYM_W-1:0],
                                           last_of_byte: 1'b1};
                     end
                  end else if (pend_valid_ff) begin
                     rsp_push.num   = 2'd1;
                     rsp_push.first = '{decoded_symbol: pend_sym_ff, last_of_byte: 1'b1};
                  end
                  if (cmd_valid && (cmd.kind == hwd_pkg::KIND_PAYLOAD)) begin
                     cmd_pop = 1'b1;
                     cur_in  = cmd;
                     idx_in  = 3'd7;
                  end else begin
                     state_in = hwd_pkg::ST_IDLE;
                  end
               end else if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_push.num   = 2'd1;
                     rsp_push.first = '{decoded_symbol: pend_sym_ff, last_of_byte: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = nxt_ptr[hwd_pkg::SYM_W-1:0];
               end
            end
         end

         default: begin
            state_in = hwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hwd_pkg::ST_IDLE;
         slot_valid_ff <= '0;
         held_ff       <= '0;
         root_ff       <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         held_ff       <= held_in;
         root_ff       <= root_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      pend_sym_ff <= pend_sym_in;
   end

   always_ff @(posedge clock) begin
      if (slot_rd_en) begin
         slot_rd_a_ff <= slot_mem[held_ff];
         slot_rd_b_ff <= slot_mem[cmd.data_byte];
      end
      if (slot_wr_en) begin
         slot_mem[held_ff] <= cur_ff.node_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (child_rd_en) begin
         child_rd_ff <= child_mem[child_rd_addr];
      end
      if (child_wr_en) begin
         child_mem[cur_ff.node_idx] <= child_wr_data;
      end
   end

endmodule

// ----- src/hwd_rsp_fifo.sv -----
// hwd_rsp_fifo: four-entry result queue, up to two writes and one read a cycle.
// Depends on hwd_pkg.
module hwd_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  hwd_pkg::rsp_push_type rsp_push,
   output logic                  rsp_room,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output hwd_pkg::rsp_type      rsp_data
);

   hwd_pkg::rsp_type q_ff [4];
   logic [1:0]       wr_ptr_ff, rd_ptr_ff, wr_ptr_next;
   logic [2:0]       count_ff, count_in;
   logic             pop;

   assign rsp_empty   = (count_ff == 3'd0);
   assign rsp_room    = (count_ff <= 3'd2);
   assign pop         = rsp_pop && !rsp_empty;
   assign rsp_data    = q_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + 2'd1;
   assign count_in    = count_ff + {1'b0, rsp_push.num} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_ff + rsp_push.num;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.num != 2'd0) begin
         q_ff[wr_ptr_ff] <= rsp_push.first;
      end
      if (rsp_push.num == 2'd2) begin
         q_ff[wr_ptr_next] <= rsp_push.second;
      end
   end

endmodule

// ----- src/huffman_tree_walk_decoder.sv -----
// huffman_tree_walk_decoder: top level of the tree-walk decoder.
// Depends on hwd_pkg, hwd_front, hwd_back and hwd_rsp_fifo.
//
//   channel   ports                          word        dir
//   --------  -----------------------------  ----------  ---
//   request   req_push, req_full, req_data   req_type    in
//   response  rsp_pop, rsp_empty, rsp_data   rsp_type    out
//
// Header bytes: the first of a pair is taken in the idle state, the second also
// passes pair-build (slot RAM read, then child/slot write). Payload bytes: one
// tree step per cycle while the result queue has room, via the registered child
// RAM read; after a header byte or an empty queue, idle issues the first read.
// Reset clears control state at once; slot entries are tracked by valid bits.
// The walker stalls while the result queue has fewer than two free entries.
module huffman_tree_walk_decoder (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             req_push,
   output logic             req_full,
   input  hwd_pkg::req_type req_data,
   // response side
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output hwd_pkg::rsp_type rsp_data
);

   logic                  cmd_valid;
   logic                  cmd_pop;
   hwd_pkg::cmd_type      cmd;
   logic                  rsp_room;
   hwd_pkg::rsp_push_type rsp_push;

   // classify incoming words: pair first/second or payload
   hwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // build the tree from header pairs, walk payload bits
   hwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push)
   );

   // decoded symbols wait here for the consumer
   hwd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sim/tb_huffman_tree_walk_decoder.sv -----
`timescale 1ns / 100ps
// tb_huffman_tree_walk_decoder: self-checking bench for the Huffman tree-walk decoder.
// Streams header and payload words, predicts every decoded symbol in the bench and
// checks the result words in order. Depends on hwd_pkg and the RTL under src.
module tb_huffman_tree_walk_decoder;

   localparam int HDR_BYTES    = 2 * (hwd_pkg::NUM_SYMBOLS - 1);  // 255 symbol pairs
   localparam int PAY_TARGET   = 460;     // random payload words before stopping
   localparam int CALM_WORDS   = 40;      // no idling once this few words remain
   localparam int HOLD_CYCLES  = 1200;    // long receiver hold-off
   localparam int SETTLE_CYCLES = 200;    // quiet time after the last result
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   // one queued request word plus the pacing hints that travel with it
   typedef struct packed {
      hwd_pkg::req_type word;
      logic             drain_first;   // hold this word back until all results are in
      logic             rsp_hold;      // start the long receiver hold-off on acceptance
      logic [6:0]       idle_pct;      // chance of a sender gap before this word
   } byte_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   hwd_pkg::req_type req_data = '0;
   logic             rsp_pop = 1'b0;
   logic             rsp_empty;
   hwd_pkg::rsp_type rsp_data;

   huffman_tree_walk_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   byte_item_type    stream_q[$];   // words still to be offered
   hwd_pkg::rsp_type symbol_q[$];   // decoded symbols still owed by the block

   // bench copy of the decoder state
   logic [8:0]  slot_tab  [0:hwd_pkg::NUM_SYMBOLS-1];
   logic [17:0] child_tab [0:hwd_pkg::NUM_SYMBOLS-2];   // {left, right}
   logic [8:0]  root_ptr;
   logic [8:0]  walk_ptr;
   logic [8:0]  hdr_cnt;
   logic [7:0]  held_sym;

   // stimulus build state
   logic [6:0] cur_idle = '0;
   logic       drain_next = 1'b0;
   logic       hold_next = 1'b0;
   int         pay_filled = 0;

   // statistics and pacing
   int               fail_cnt = 0;
   int               rx_cnt = 0;
   int               hdr_seen = 0;
   int               pay_seen = 0;
   int               sof_seen = 0;
   int               cycle_cnt = 0;
   int               hold_requests = 0;
   int               holds_done = 0;
   int               hold_left = 0;
   int               req_gap = 0;
   int               rsp_gap = 0;
   int               rsp_pct = 0;
   int               rsp_mode_cnt = 0;
   logic             req_taken = 1'b0;
   hwd_pkg::rsp_type want_word;

   // pointers 256..510 are internal nodes, everything else is a leaf
   function automatic logic is_node(input logic [8:0] p);
      return (p >= 9'd256) && (p <= 9'd510);
   endfunction

   // Advance the bench state by one accepted word and queue the symbols it yields.
   task automatic decode_word(input hwd_pkg::req_type w);
      hwd_pkg::rsp_type hits [0:7];
      hwd_pkg::rsp_type r;
      int               n;
      n = 0;
      if (w.start_of_file) begin
         for (int i = 0; i < hwd_pkg::NUM_SYMBOLS; i++) slot_tab[i] = 9'(i);
         hdr_cnt = '0;
         sof_seen++;
      end
      if (hdr_cnt < HDR_BYTES) begin
         // header: even count holds the first symbol, odd count builds node k
         hdr_seen++;
         if (!hdr_cnt[0]) begin
            held_sym = w.data_byte;
         end else begin
            child_tab[hdr_cnt[8:1]] = {slot_tab[held_sym], slot_tab[w.data_byte]};
            slot_tab[held_sym] = {1'b1, hdr_cnt[8:1]};
            // repeated symbol: this undoes the node pointer just written
            slot_tab[w.data_byte] = {1'b0, w.data_byte};
            if (hdr_cnt == HDR_BYTES - 1) begin
               root_ptr = slot_tab[held_sym];
               walk_ptr = root_ptr;
            end
         end
         hdr_cnt = hdr_cnt + 1'b1;
      end else begin
         // payload: MSB first, 1 goes right, 0 goes left; walk carries over bytes
         pay_seen++;
         for (int i = 7; i >= 0; i--) begin
            if (is_node(walk_ptr))
               walk_ptr = w.data_byte[i] ? child_tab[walk_ptr[7:0]][8:0]
                                         : child_tab[walk_ptr[7:0]][17:9];
            if (!is_node(walk_ptr)) begin
               hits[n].decoded_symbol = walk_ptr[7:0];
               hits[n].last_of_byte = 1'b0;
               n++;
               walk_ptr = root_ptr;
            end
         end
         for (int i = 0; i < n; i++) begin
            r = hits[i];
            r.last_of_byte = (i == n - 1);
            symbol_q.push_back(r);
         end
      end
   endtask

   task automatic add_word(input logic [7:0] d, input logic sof);
      byte_item_type it;
      it.word.data_byte = d;
      it.word.start_of_file = sof;
      it.drain_first = drain_next;
      it.rsp_hold = hold_next;
      it.idle_pct = cur_idle;
      drain_next = 1'b0;
      hold_next = 1'b0;
      stream_q.push_back(it);
   endtask

   task automatic add_pair(input logic [7:0] a, input logic [7:0] b, input logic sof);
      add_word(a, sof);
      add_word(b, 1'b0);
   endtask

   // Well-formed header: merge two live subtrees per pair, the survivor keeps the
   // first slot. Skewed mode keeps reusing the newest node and grows deep trees.
   task automatic add_tree_header(input logic skew);
      int act[$];
      int ia;
      int ib;
      int a;
      int b;
      for (int i = 0; i < hwd_pkg::NUM_SYMBOLS; i++) act.push_back(i);
      for (int p = 0; p < hwd_pkg::NUM_SYMBOLS - 1; p++) begin
         if (skew && ($urandom_range(0, 3) != 0)) ia = act.size() - 1;
         else ia = $urandom_range(0, act.size() - 1);
         a = act[ia];
         act.delete(ia);
         ib = $urandom_range(0, act.size() - 1);
         b = act[ib];
         act.delete(ib);
         act.push_back(a);
         add_pair(8'(a), 8'(b), p == 0);
      end
   endtask

   // Random header bytes; a short count leaves the header cut off by the next file.
   task automatic add_noise_header(input int nbytes, input logic leaf_root);
      logic [7:0] d;
      logic [7:0] prev_d;
      prev_d = '0;
      for (int i = 0; i < nbytes; i++) begin
         d = 8'($urandom_range(0, 255));
         // last pair repeated: root ends up a leaf
         if (leaf_root && (i == HDR_BYTES - 1)) d = prev_d;
         add_word(d, i == 0);
         prev_d = d;
      end
   endtask

   task automatic add_payload(input int n);
      for (int i = 0; i < n; i++) add_word(8'($urandom_range(0, 255)), 1'b0);
      pay_filled += n;
   endtask

   //------------------------------------------------------------------------
   // Clock and cycle limit
   //------------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d symbols still owed", cycle_cnt, symbol_q.size());
      $display("status: fail");
      $finish;
   end

   //------------------------------------------------------------------------
   // Request driver: bookkeeping at the rising edge, drive at the falling edge
   //------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_push && !req_full) begin
         req_taken = 1'b1;
         if (stream_q[0].rsp_hold) hold_requests++;
         decode_word(req_data);
         void'(stream_q.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         // a word that is still waiting for acceptance is simply held
         if (req_gap > 0) begin
            req_gap--;
            req_push <= 1'b0;
         end else if (stream_q.size() == 0) begin
            req_push <= 1'b0;
         end else if (stream_q[0].drain_first && (symbol_q.size() != 0)) begin
            req_push <= 1'b0;
         end else if ((stream_q.size() > CALM_WORDS) &&
                      ($urandom_range(0, 99) < stream_q[0].idle_pct)) begin
            req_gap = $urandom_range(0, 3);
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_data <= stream_q[0].word;
         end
      end
   end

   //------------------------------------------------------------------------
   // Response monitor: check at the rising edge, pace pop at the falling edge
   //------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         rx_cnt++;
         if (symbol_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $display("unexpected word: symbol %02h last %0d",
                        rsp_data.decoded_symbol, rsp_data.last_of_byte);
         end else begin
            want_word = symbol_q.pop_front();
            if ((rsp_data.decoded_symbol !== want_word.decoded_symbol) ||
                (rsp_data.last_of_byte !== want_word.last_of_byte)) begin
               fail_cnt++;
               if (fail_cnt <= MAX_REPORTS)
                  $display("mismatch on word %0d: expected symbol %02h last %0d, got %02h last %0d",
                           rx_cnt, want_word.decoded_symbol, want_word.last_of_byte,
                           rsp_data.decoded_symbol, rsp_data.last_of_byte);
            end
         end
      end
   end

   always @(negedge clock) begin
      // receiver idle rate is redrawn whenever the mode counter runs out, zero is one choice
      if (rsp_mode_cnt == 0) begin
         rsp_mode_cnt = 300;
         case ($urandom_range(0, 2))
            0: rsp_pct = 0;
            1: rsp_pct = 15;
            default: rsp_pct = 40;
         endcase
      end
      rsp_mode_cnt--;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (holds_done != hold_requests) begin
         // long hold-off: the block fills up and has to stall its input
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_pop <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_pop <= 1'b0;
      end else if ((stream_q.size() > CALM_WORDS) && ($urandom_range(0, 99) < rsp_pct)) begin
         rsp_gap = $urandom_range(0, 3);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   //------------------------------------------------------------------------
   // Stimulus and end of run
   //------------------------------------------------------------------------
   initial begin
      int k;
      int step;
      int file_no;
      int pick;

      for (int i = 0; i < hwd_pkg::NUM_SYMBOLS; i++) slot_tab[i] = 9'(i);
      for (int i = 0; i < hwd_pkg::NUM_SYMBOLS - 1; i++) child_tab[i] = '0;
      root_ptr = '0;
      walk_ptr = '0;
      hdr_cnt = '0;
      held_sym = '0;

      // Directed file A, straight after reset without start_of_file: repeated
      // symbol in the first and last pair, so the root is the leaf 0xFF and
      // every payload bit yields a symbol.
      cur_idle = 7'd20;
      add_pair(8'h00, 8'h00, 1'b0);
      for (k = 1; k < 254; k++) add_pair(8'(k), 8'(k + 1), 1'b0);
      add_pair(8'hFF, 8'hFF, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'hFF, 1'b0);
      add_word(8'h5A, 1'b0);

      // Directed file B: perfectly balanced tree, one symbol per byte
      for (step = 1; step < hwd_pkg::NUM_SYMBOLS; step = step * 2)
         for (k = 0; k < hwd_pkg::NUM_SYMBOLS; k = k + 2 * step)
            add_pair(8'(k), 8'(k + step), (step == 1) && (k == 0));
      add_word(8'h00, 1'b0);
      add_word(8'hFF, 1'b0);
      add_word(8'h80, 1'b0);
      add_word(8'h01, 1'b0);
      add_word(8'h5A, 1'b0);
      add_word(8'hC3, 1'b0);

      // Directed file C: 255-deep chain, zeros reach no leaf and the walk
      // carries across bytes; sender waits for all results before it starts
      drain_next = 1'b1;
      for (k = 1; k < hwd_pkg::NUM_SYMBOLS; k++) add_pair(8'h00, 8'(k), k == 1);
      add_word(8'hFF, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'h80, 1'b0);
      add_word(8'h55, 1'b0);
      add_word(8'h01, 1'b0);
      add_word(8'hAA, 1'b0);

      // Random files: mostly well-formed trees with random payload, some noise
      // headers and some headers cut short by the next start_of_file.
      file_no = 0;
      while (pay_filled < PAY_TARGET) begin
         case ($urandom_range(0, 2))
            0: cur_idle = 7'd0;
            1: cur_idle = 7'd10;
            default: cur_idle = 7'd35;
         endcase
         if (file_no == 3) drain_next = 1'b1;
         if (file_no == 1) begin
            // leaf root gives 8 words per byte while the receiver holds off
            add_noise_header(HDR_BYTES, 1'b1);
            hold_next = 1'b1;
            add_payload(64);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               add_tree_header(1'($urandom_range(0, 1)));
               add_payload($urandom_range(8, 50));
            end else if (pick < 85) begin
               add_noise_header(HDR_BYTES, $urandom_range(0, 3) == 0);
               add_payload($urandom_range(8, 40));
            end else begin
               add_noise_header($urandom_range(1, HDR_BYTES - 1), 1'b0);
            end
         end
         file_no++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((stream_q.size() != 0) || (symbol_q.size() != 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d files (%0d started by start_of_file), %0d header words",
               sof_seen + 1, sof_seen, hdr_seen);
      $display("and %0d payload words; checked %0d decoded symbols in %0d cycles, %0d failures",
               pay_seen, rx_cnt, cycle_cnt, fail_cnt);
      if ((fail_cnt == 0) && (symbol_q.size() == 0)) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
